/* hw/rtl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// Byte pre-tokenizer splitter package
// Shared types, byte class codes and the classification function.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned WinDepth  = 3;

  localparam logic [ByteW-1:0] ChApos  = 8'h27;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChVt    = 8'h0b;
  localparam logic [ByteW-1:0] ChFf    = 8'h0c;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChLowS  = 8'h73;
  localparam logic [ByteW-1:0] ChLowT  = 8'h74;
  localparam logic [ByteW-1:0] ChLowM  = 8'h6d;
  localparam logic [ByteW-1:0] ChLowD  = 8'h64;
  localparam logic [ByteW-1:0] ChLowR  = 8'h72;
  localparam logic [ByteW-1:0] ChLowV  = 8'h76;
  localparam logic [ByteW-1:0] ChLowL  = 8'h6c;
  localparam logic [ByteW-1:0] ChLowE  = 8'h65;
  localparam logic [ByteW-1:0] ChHigh  = 8'h80;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_LETTER = 3'd1,
    KIND_DIGIT  = 3'd2,
    KIND_SYMBOL = 3'd3,
    KIND_SPACE  = 3'd4,
    KIND_PREFIX = 3'd5
  } kind_e;

  // One byte ready for the boundary decision, with its lookahead.
  typedef struct packed {
    logic [ByteW-1:0] cur;
    logic             v1;
    logic [ByteW-1:0] n1;
    logic             v2;
    logic [ByteW-1:0] n2;
    logic             last;
  } entry_t;

  function automatic kind_e class_of(input logic [ByteW-1:0] c);
    kind_e k;
    if (((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a)) || (c >= ChHigh)) begin
      k = KIND_LETTER;
    end else if ((c >= 8'h30) && (c <= 8'h39)) begin
      k = KIND_DIGIT;
    end else if ((c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr) ||
                 (c == ChVt) || (c == ChFf)) begin
      k = KIND_SPACE;
    end else begin
      k = KIND_SYMBOL;
    end
    return k;
  endfunction

endpackage

/* hw/rtl/byte_pretokenizer_splitter.sv */
// ----------------------------------------------------------------------------
// Byte pre-tokenizer splitter
// Marks the first byte of every pre-token piece in a stream of text bytes.
// ----------------------------------------------------------------------------
// Each input word carries one byte of a text segment; each output word gives
// the same byte back, in order, with piece_start_o set where a new piece
// begins and segment_end_o set on the segment's final byte. A piece is an
// apostrophe contraction ('s 't 'm 'd 're 've 'll) where a piece would begin,
// an optional single space followed by a run of letters, digits or symbols
// (bytes at or above 0x80 are letters), or a run of whitespace. Two bytes of
// lookahead are held, so an output word leaves only once the second byte
// after it has arrived, or once segment_last_i has been seen. In steady flow
// the block takes and gives one word per clock; a byte released by an input
// word passes through the window, the queue and the output register. A word
// with segment_last_i set makes the front end drain its window, one held
// byte per cycle while the queue has room, and the input stalls until the
// window is empty at each segment end. A four-entry queue separates the
// front end from the decision logic, and a registered output stage lets the
// input keep flowing while a finished word waits to be taken.
// ----------------------------------------------------------------------------
module byte_pretokenizer_splitter import bps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             segment_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] byte_out_o,
  output logic             piece_start_o,
  output logic             segment_end_o
);

  entry_t push_entry, pop_entry;
  logic   push, full, pop, empty;

  // The front end owns the lookahead window and the segment-end drain.
  bps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_in_i      (byte_in_i),
    .segment_last_i (segment_last_i),
    .push_o         (push),
    .entry_o        (push_entry),
    .full_i         (full)
  );

  // The queue lets the output side stall without blocking the window.
  bps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .empty_o (empty)
  );

  // The back end keeps the piece state and registers each result word.
  bps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (pop_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_out_o    (byte_out_o),
    .piece_start_o (piece_start_o),
    .segment_end_o (segment_end_o)
  );

endmodule

/* hw/rtl/bps_front.sv */
// ----------------------------------------------------------------------------
// Splitter front end
// Holds the lookahead window and hands each byte with its two followers
// to the queue. Drains the window on a segment end, one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
module bps_front import bps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             segment_last_i,
  output logic             push_o,
  output entry_t           entry_o,
  input  logic             full_i
);

  logic [ByteW-1:0] win_q [WinDepth];
  logic [ByteW-1:0] win_d [WinDepth];
  logic [1:0]       cnt_q, cnt_d, cnt_pop;
  logic             flush_q, flush_d;
  logic             pop, accept;

  assign pop        = ((cnt_q == 2'd3) || (flush_q && (cnt_q != 2'd0))) && !full_i;
  assign in_ready_o = !flush_q && ((cnt_q != 2'd3) || pop);
  assign accept     = in_valid_i && in_ready_o;

  assign push_o        = pop;
  assign entry_o.cur   = win_q[0];
  assign entry_o.v1    = cnt_q >= 2'd2;
  assign entry_o.n1    = win_q[1];
  assign entry_o.v2    = cnt_q == 2'd3;
  assign entry_o.n2    = win_q[2];
  assign entry_o.last  = flush_q && (cnt_q == 2'd1);

  always_comb begin
    win_d   = win_q;
    cnt_pop = cnt_q;
    if (pop) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      cnt_pop  = cnt_q - 2'd1;
    end
    cnt_d = cnt_pop;
    if (accept) begin
      win_d[cnt_pop] = byte_in_i;
      cnt_d          = cnt_pop + 2'd1;
    end
  end

  always_comb begin
    flush_d = flush_q;
    if (accept && segment_last_i) begin
      flush_d = 1'b1;
    end else if (pop && flush_q && (cnt_q == 2'd1)) begin
      flush_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      flush_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

/* hw/rtl/bps_fifo.sv */
// ----------------------------------------------------------------------------
// Splitter queue
// Short first-in first-out queue of decision entries between front and back.
// ----------------------------------------------------------------------------
module bps_fifo import bps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   empty_o
);

  entry_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == (FifoPtrW+1)'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (FifoPtrW+1)'(do_push) - (FifoPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/bps_back.sv */
// ----------------------------------------------------------------------------
// Splitter back end
// Tracks the piece in progress, decides the piece boundary for each byte
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module bps_back import bps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  entry_t           entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] byte_out_o,
  output logic             piece_start_o,
  output logic             segment_end_o
);

  kind_e            run_q, run_d;
  logic [1:0]       left_q, left_d;
  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             start_q, start_d, end_q;
  kind_e            k;
  logic             short_c, long_c;

  assign pop_o = !empty_i && (!valid_q || out_ready_i);
  assign k     = class_of(entry_i.cur);

  assign short_c = (entry_i.n1 == ChLowS) || (entry_i.n1 == ChLowT) ||
                   (entry_i.n1 == ChLowM) || (entry_i.n1 == ChLowD);
  assign long_c  = entry_i.v2 &&
                   (((entry_i.n1 == ChLowR) && (entry_i.n2 == ChLowE)) ||
                    ((entry_i.n1 == ChLowV) && (entry_i.n2 == ChLowE)) ||
                    ((entry_i.n1 == ChLowL) && (entry_i.n2 == ChLowL)));

  always_comb begin
    run_d   = run_q;
    left_d  = left_q;
    start_d = 1'b0;
    if (left_q != 2'd0) begin
      left_d = left_q - 2'd1;
    end else if (run_q == KIND_PREFIX) begin
      run_d = k;
    end else if ((run_q != KIND_NONE) && (run_q == k)) begin
      start_d = 1'b0;
    end else begin
      start_d = 1'b1;
      run_d   = k;
      if ((entry_i.cur == ChApos) && entry_i.v1) begin
        if (short_c) begin
          left_d = 2'd1;
          run_d  = KIND_NONE;
        end else if (long_c) begin
          left_d = 2'd2;
          run_d  = KIND_NONE;
        end
      end else if (entry_i.cur == ChSpace) begin
        run_d = KIND_PREFIX;
      end
    end
    // The segment's final byte returns the piece state to its start value.
    if (entry_i.last) begin
      run_d  = KIND_NONE;
      left_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= KIND_NONE;
      left_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        run_q   <= run_d;
        left_q  <= left_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q  <= entry_i.cur;
      start_q <= start_d;
      end_q   <= entry_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign byte_out_o    = byte_q;
  assign piece_start_o = start_q;
  assign segment_end_o = end_q;

endmodule

/* hw/rtl/bps_checker.sv */
// ----------------------------------------------------------------------------
// Splitter port checker
// Watches the top level's ports for handshake and boundary rules.
// ----------------------------------------------------------------------------
module bps_checker import bps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_o,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             segment_last_i,
  input  logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic [ByteW-1:0] byte_out_o,
  input  logic             piece_start_o,
  input  logic             segment_end_o
);

  logic seg_first_q;

  // Set while the next output word is the first of a segment.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_first_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      seg_first_q <= segment_end_o;
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(byte_in_i) && $stable(segment_last_i))
    else $error("input word changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(byte_out_o) && $stable(piece_start_o) &&
      $stable(segment_end_o))
    else $error("output word changed while stalled");

  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && segment_last_i |=> !in_ready_o)
    else $error("input taken while the window drains");

  a_first_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seg_first_q |-> piece_start_o)
    else $error("first byte of a segment does not begin a piece");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !segment_last_i && !out_valid_o && seg_first_q &&
      $past(!rst_ni) |=> !out_valid_o)
    else $error("output word appeared without enough lookahead");

endmodule

bind byte_pretokenizer_splitter bps_checker u_bps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .byte_in_i      (byte_in_i),
  .segment_last_i (segment_last_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .byte_out_o     (byte_out_o),
  .piece_start_o  (piece_start_o),
  .segment_end_o  (segment_end_o)
);
